// ===== sv/plwe_pkg.sv =====
// Package for the parallel LED wire encoder: queue entry type, wire word
// constants and the slice transpose and spread functions. No dependencies.
package plwe_pkg;

  localparam int unsigned PORTS     = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned BIT_IDX_W = 3;

  localparam logic [WORD_W-1:0] WIRE_BASE = 16'h0010;

  typedef logic [PORTS-1:0][BYTE_W-1:0] plwe_ports_t;
  typedef logic [BYTE_W-1:0][WORD_W-1:0] plwe_words_t;

  // One decoded item: the data word for each bit position plus the latch flag.
  typedef struct packed {
    plwe_words_t data_words;
    logic        frame_end;
  } plwe_entry_t;

  // Fixed wire bit placement of a slice byte on top of the base pattern.
  function automatic logic [WORD_W-1:0] spread(input logic [BYTE_W-1:0] q);
    logic [WORD_W-1:0] w;
    w     = WIRE_BASE;
    w[10] = w[10] | q[0];
    w[14] = w[14] | q[1];
    w[2]  = w[2]  | q[2];
    w[6]  = w[6]  | q[3];
    w[9]  = w[9]  | q[4];
    w[13] = w[13] | q[5];
    w[1]  = w[1]  | q[6];
    w[5]  = w[5]  | q[7];
    return w;
  endfunction

  // Ports 4..7 land in slice bits 0..3, ports 0..3 in slice bits 4..7.
  function automatic logic [BYTE_W-1:0] slice_at(input plwe_ports_t ports,
                                                 input logic [BIT_IDX_W-1:0] pos);
    logic [BYTE_W-1:0] s;
    s = '0;
    for (int p = 0; p < 4; p++) begin
      s[p]     = ports[4 + p][pos];
      s[4 + p] = ports[p][pos];
    end
    return s;
  endfunction

  localparam logic [WORD_W-1:0] SPREAD_HIGH = 16'h6676;
  localparam logic [WORD_W-1:0] SPREAD_LOW  = 16'h0010;

endpackage

// ===== sv/plwe_if.sv =====
// Valid/ready channel interfaces of the parallel LED wire encoder.
// Depends on nothing; widths match the fields of plwe_pkg.
interface plwe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] port0_byte;
  logic [7:0] port1_byte;
  logic [7:0] port2_byte;
  logic [7:0] port3_byte;
  logic [7:0] port4_byte;
  logic [7:0] port5_byte;
  logic [7:0] port6_byte;
  logic [7:0] port7_byte;
  logic       frame_end;

  modport source (
    output valid, port0_byte, port1_byte, port2_byte, port3_byte,
           port4_byte, port5_byte, port6_byte, port7_byte, frame_end,
    input  ready
  );
  modport sink (
    input  valid, port0_byte, port1_byte, port2_byte, port3_byte,
           port4_byte, port5_byte, port6_byte, port7_byte, frame_end,
    output ready
  );
endinterface

interface plwe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] wire_word;
  logic        run_last;

  modport source (output valid, wire_word, run_last, input ready);
  modport sink   (input  valid, wire_word, run_last, output ready);
endinterface

// ===== sv/plwe_front.sv =====
// Front end: accepts input beats, transposes and spreads all eight slices.
// Depends on plwe_pkg and plwe_in_if.
module plwe_front
  import plwe_pkg::*;
(
  plwe_in_if.sink     in_i,
  input  logic        full_i,
  output logic        push_o,
  output plwe_entry_t entry_o
);

  plwe_ports_t ports;

  assign ports = {in_i.port7_byte, in_i.port6_byte, in_i.port5_byte,
                  in_i.port4_byte, in_i.port3_byte, in_i.port2_byte,
                  in_i.port1_byte, in_i.port0_byte};

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    for (int b = 0; b < BYTE_W; b++) begin
      entry_o.data_words[b] = spread(slice_at(ports, BIT_IDX_W'(b)));
    end
    entry_o.frame_end = in_i.frame_end;
  end

endmodule

// ===== sv/plwe_queue.sv =====
// Small FIFO of decoded items between the front and back ends.
// Depends on plwe_pkg.
module plwe_queue
  import plwe_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  plwe_entry_t entry_i,
  input  logic        pop_i,
  output logic        full_o,
  output logic        valid_o,
  output plwe_entry_t entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  plwe_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/plwe_back.sv =====
// Back end: walks each item's bit positions and emits one wire word per beat
// through a registered output. Depends on plwe_pkg and plwe_out_if.
module plwe_back
  import plwe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  plwe_entry_t entry_i,
  output logic        pop_o,
  plwe_out_if.source  out_o
);

  typedef enum logic [1:0] {
    PH_HIGH,
    PH_DATA,
    PH_LOW,
    PH_LATCH
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic                 active_q, active_d;
  plwe_entry_t          cur_q, cur_d;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_W-1:0]    word_q, word_d;
  logic                 last_q, last_d;

  logic                 can_load;
  logic                 emit;
  logic [WORD_W-1:0]    word_sel;
  logic                 last_sel;

  assign can_load = !out_valid_q || out_o.ready;
  assign emit     = active_q && can_load;

  always_comb begin
    word_sel = SPREAD_LOW;
    last_sel = 1'b0;
    unique case (phase_q)
      PH_HIGH:  word_sel = SPREAD_HIGH;
      PH_DATA:  word_sel = cur_q.data_words[bit_q];
      PH_LOW: begin
        word_sel = SPREAD_LOW;
        last_sel = (bit_q == '0) && !cur_q.frame_end;
      end
      PH_LATCH: begin
        word_sel = SPREAD_LOW;
        last_sel = 1'b1;
      end
      default: begin
        word_sel = SPREAD_LOW;
        last_sel = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    bit_d       = bit_q;
    active_d    = active_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_o.ready;
    word_d      = word_q;
    last_d      = last_q;
    pop_o       = 1'b0;

    if (emit) begin
      out_valid_d = 1'b1;
      word_d      = word_sel;
      last_d      = last_sel;
      if (last_sel) begin
        // Pick up the next item right away so words keep flowing.
        active_d = valid_i;
        pop_o    = valid_i;
        cur_d    = entry_i;
        phase_d  = PH_HIGH;
        bit_d    = BIT_IDX_W'(BYTE_W - 1);
      end else begin
        unique case (phase_q)
          PH_HIGH: phase_d = PH_DATA;
          PH_DATA: phase_d = PH_LOW;
          PH_LOW: begin
            if (bit_q == '0) begin
              phase_d = PH_LATCH;
            end else begin
              phase_d = PH_HIGH;
              bit_d   = bit_q - 1'b1;
            end
          end
          default: phase_d = PH_HIGH;
        endcase
      end
    end else if (!active_q && valid_i) begin
      active_d = 1'b1;
      pop_o    = 1'b1;
      cur_d    = entry_i;
      phase_d  = PH_HIGH;
      bit_d    = BIT_IDX_W'(BYTE_W - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HIGH;
      bit_q       <= '0;
      active_q    <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      word_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      active_q    <= active_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      word_q      <= word_d;
      last_q      <= last_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.wire_word = word_q;
  assign out_o.run_last  = last_q;

endmodule

// ===== sv/parallel_led_wire_encoder.sv =====
// Parallel LED wire encoder, top level. Depends on plwe_pkg, plwe_if,
// plwe_front, plwe_queue and plwe_back.
// An item's first wire word passes the queue, the back end's item register
// and the output register. Each item gives 24 words, 25 with frame_end set;
// the single output word port, one word per cycle while out_o.ready holds,
// sets the item rate. Reset at once clears the queue and any pending word.
module parallel_led_wire_encoder
  import plwe_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plwe_in_if.sink    in_i,
  plwe_out_if.source out_o
);

  // The front end transposes the eight port bytes into slices and spreads
  // every slice to its wire word in the cycle of the input beat. The whole
  // decoded item then waits in the queue, so new beats are taken while the
  // back end is still streaming an earlier item.
  logic        push;
  logic        full;
  plwe_entry_t front_entry;

  // The back end pops one item at a time and emits, for each bit position
  // from the most significant down, the high word, the data word and the
  // low word, and then the latch word when the item closes a frame. It pops
  // the next item in the cycle that it emits the last word of the current
  // one, so consecutive items stream without a gap.
  logic        pop;
  logic        q_valid;
  plwe_entry_t q_entry;

  plwe_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (front_entry)
  );

  plwe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  plwe_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
